@@ rtl/core/line_intersection_2d_defines.svh @@
// Assertion macros used by the checker file lix2d_checker.sv.
`ifndef LINE_INTERSECTION_2D_DEFINES_SVH
`define LINE_INTERSECTION_2D_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LIX2D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line intersection check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LIX2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line intersection check failed");

`endif

@@ rtl/core/lix2d_pkg.sv @@
`timescale 1ns / 1ps

package lix2d_pkg;

  localparam int unsigned QBITS = 40;
  localparam logic [30:0] MIN_SINE_RESET = 31'd215;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_PARALLEL = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] dir1_x;
    logic signed [31:0] dir1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] dir2_x;
    logic signed [31:0] dir2_y;
  } in_beat_t;

  typedef struct packed {
    logic [127:0]       sq;
    logic [127:0]       l12;
    logic [95:0]        n_x;
    logic [95:0]        n_y;
    logic [63:0]        md;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
  } geo_t;

  typedef struct packed {
    logic [95:0]        n_x;
    logic [95:0]        n_y;
    logic [63:0]        md;
    logic               neg_x;
    logic               neg_y;
    logic               par;
    logic               big_x;
    logic               big_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
  } div_in_t;

  typedef struct packed {
    logic [63:0]        rem_x;
    logic [63:0]        rem_y;
    logic [63:0]        md;
    logic [QBITS-1:0]   acc_x;
    logic [QBITS-1:0]   acc_y;
    logic               neg_x;
    logic               neg_y;
    logic               par;
    logic               big_x;
    logic               big_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
  } div_st_t;

  typedef struct packed {
    logic [31:0] cross_x;
    logic [31:0] cross_y;
    logic [1:0]  status;
  } res_t;

endpackage

@@ rtl/core/line_intersection_2d.sv @@
`timescale 1ns / 1ps

// Channel   Valid       Stall       Beat contents
// in        in_valid    in_stall    in_p1_x .. in_dir2_y, signed Q16.16
// out       out_valid   out_stall   out_cross_x, out_cross_y, out_status
// cfg       cfg_wr_en   (none)      cfg_wr_data, min_sine in unsigned Q0.31
//
// One beat is accepted per cycle while in_stall is low.
// The core of the pipeline is a 40-stage restoring divider, one quotient bit per stage.
// Reset is synchronous on rst_n; min_sine returns to 215 and the pipeline empties.
// When the output is stalled, one more result lands in a skid register and then
// the whole pipeline holds, raising in_stall until the skid register drains.

module line_intersection_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_p1_x,
  input  logic [31:0] in_p1_y,
  input  logic [31:0] in_dir1_x,
  input  logic [31:0] in_dir1_y,
  input  logic [31:0] in_p2_x,
  input  logic [31:0] in_p2_y,
  input  logic [31:0] in_dir2_x,
  input  logic [31:0] in_dir2_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cross_x,
  output logic [31:0] out_cross_y,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);
  import lix2d_pkg::*;

  logic [30:0] min_sine_r;
  logic        en;
  in_beat_t    beat;
  logic        geo_v, div_in_v, div_out_v;
  geo_t        geo;
  div_in_t     div_in;
  div_st_t     div_out;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sine_r <= MIN_SINE_RESET;
    end else if (cfg_wr_en) begin
      min_sine_r <= cfg_wr_data;
    end
  end

  assign beat.p1_x   = in_p1_x;
  assign beat.p1_y   = in_p1_y;
  assign beat.dir1_x = in_dir1_x;
  assign beat.dir1_y = in_dir1_y;
  assign beat.p2_x   = in_p2_x;
  assign beat.p2_y   = in_p2_y;
  assign beat.dir2_x = in_dir2_x;
  assign beat.dir2_y = in_dir2_y;

  lix2d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid),
    .in_beat (beat),
    .out_v   (geo_v),
    .out_geo (geo)
  );

  lix2d_test u_test (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .min_sine (min_sine_r),
    .in_v     (geo_v),
    .in_geo   (geo),
    .out_v    (div_in_v),
    .out_div  (div_in)
  );

  lix2d_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (div_in_v),
    .in_div (div_in),
    .out_v  (div_out_v),
    .out_st (div_out)
  );

  lix2d_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (div_out_v),
    .in_st     (div_out),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign in_stall    = !en;
  assign out_cross_x = res.cross_x;
  assign out_cross_y = res.cross_y;
  assign out_status  = res.status;

endmodule

@@ rtl/core/lix2d_front.sv @@
`timescale 1ns / 1ps

module lix2d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  lix2d_pkg::in_beat_t in_beat,
  output logic                out_v,
  output lix2d_pkg::geo_t     out_geo
);
  import lix2d_pkg::*;

  logic [4:0] v_r;

  logic signed [31:0] a_p1x_r, a_p1y_r, a_r1x_r, a_r1y_r, a_r2x_r, a_r2y_r;
  logic signed [32:0] a_dx_r, a_dy_r;

  logic signed [31:0] b_p1x_r, b_p1y_r;
  logic signed [63:0] b_r1xx_r, b_r1yy_r, b_r2xx_r, b_r2yy_r, b_ad_r, b_bd_r;
  logic signed [64:0] b_cy_r, b_cx_r;
  logic [31:0]        b_ar1x_r, b_ar1y_r;
  logic               b_s1x_r, b_s1y_r;

  logic [64:0] d_nxt;
  logic [65:0] c_nxt;
  logic [63:0] md_nxt, mc_nxt;

  logic signed [31:0] c_p1x_r, c_p1y_r;
  logic [63:0]        c_l1_r, c_l2_r, c_md_r, c_mc_r;
  logic [31:0]        c_ar1x_r, c_ar1y_r;
  logic               c_negx_r, c_negy_r;

  logic signed [31:0] d_p1x_r, d_p1y_r;
  logic [63:0] d_mll_r, d_mlh_r, d_mhh_r;
  logic [63:0] d_ll_r, d_lh_r, d_hl_r, d_hh_r;
  logic [63:0] d_xl_r, d_xh_r, d_yl_r, d_yh_r;
  logic [63:0] d_md_r;
  logic        d_negx_r, d_negy_r, d_zero_r;

  geo_t e_geo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  assign d_nxt  = {b_ad_r[63], b_ad_r} - {b_bd_r[63], b_bd_r};
  assign c_nxt  = {b_cy_r[64], b_cy_r} - {b_cx_r[64], b_cx_r};
  assign md_nxt = d_nxt[64] ? 64'(~d_nxt + 65'd1) : d_nxt[63:0];
  assign mc_nxt = c_nxt[65] ? 64'(~c_nxt + 66'd1) : c_nxt[63:0];

  always_ff @(posedge clk) begin
    if (en) begin
      a_p1x_r <= in_beat.p1_x;
      a_p1y_r <= in_beat.p1_y;
      a_r1x_r <= in_beat.dir1_x;
      a_r1y_r <= in_beat.dir1_y;
      a_r2x_r <= in_beat.dir2_x;
      a_r2y_r <= in_beat.dir2_y;
      a_dx_r  <= {in_beat.p2_x[31], in_beat.p2_x} - {in_beat.p1_x[31], in_beat.p1_x};
      a_dy_r  <= {in_beat.p2_y[31], in_beat.p2_y} - {in_beat.p1_y[31], in_beat.p1_y};

      b_p1x_r  <= a_p1x_r;
      b_p1y_r  <= a_p1y_r;
      b_r1xx_r <= a_r1x_r * a_r1x_r;
      b_r1yy_r <= a_r1y_r * a_r1y_r;
      b_r2xx_r <= a_r2x_r * a_r2x_r;
      b_r2yy_r <= a_r2y_r * a_r2y_r;
      b_ad_r   <= a_r1x_r * a_r2y_r;
      b_bd_r   <= a_r1y_r * a_r2x_r;
      b_cy_r   <= a_r2x_r * a_dy_r;
      b_cx_r   <= a_r2y_r * a_dx_r;
      b_ar1x_r <= a_r1x_r[31] ? $unsigned(-a_r1x_r) : $unsigned(a_r1x_r);
      b_ar1y_r <= a_r1y_r[31] ? $unsigned(-a_r1y_r) : $unsigned(a_r1y_r);
      b_s1x_r  <= a_r1x_r[31];
      b_s1y_r  <= a_r1y_r[31];

      c_p1x_r  <= b_p1x_r;
      c_p1y_r  <= b_p1y_r;
      c_l1_r   <= $unsigned(b_r1xx_r) + $unsigned(b_r1yy_r);
      c_l2_r   <= $unsigned(b_r2xx_r) + $unsigned(b_r2yy_r);
      c_md_r   <= md_nxt;
      c_mc_r   <= mc_nxt;
      c_ar1x_r <= b_ar1x_r;
      c_ar1y_r <= b_ar1y_r;
      c_negx_r <= ~(b_s1x_r ^ c_nxt[65] ^ d_nxt[64]);
      c_negy_r <= ~(b_s1y_r ^ c_nxt[65] ^ d_nxt[64]);

      d_p1x_r  <= c_p1x_r;
      d_p1y_r  <= c_p1y_r;
      d_mll_r  <= c_md_r[31:0] * c_md_r[31:0];
      d_mlh_r  <= c_md_r[31:0] * c_md_r[63:32];
      d_mhh_r  <= c_md_r[63:32] * c_md_r[63:32];
      d_ll_r   <= c_l1_r[31:0] * c_l2_r[31:0];
      d_lh_r   <= c_l1_r[31:0] * c_l2_r[63:32];
      d_hl_r   <= c_l1_r[63:32] * c_l2_r[31:0];
      d_hh_r   <= c_l1_r[63:32] * c_l2_r[63:32];
      d_xl_r   <= c_ar1x_r * c_mc_r[31:0];
      d_xh_r   <= c_ar1x_r * c_mc_r[63:32];
      d_yl_r   <= c_ar1y_r * c_mc_r[31:0];
      d_yh_r   <= c_ar1y_r * c_mc_r[63:32];
      d_md_r   <= c_md_r;
      d_negx_r <= c_negx_r;
      d_negy_r <= c_negy_r;
      d_zero_r <= (c_l1_r == '0) || (c_l2_r == '0) || (c_md_r == '0);

      e_geo_r.sq    <= {64'd0, d_mll_r} + {31'd0, d_mlh_r, 33'd0} + {d_mhh_r, 64'd0};
      e_geo_r.l12   <= {64'd0, d_ll_r} + {32'd0, d_lh_r, 32'd0} + {32'd0, d_hl_r, 32'd0}
                     + {d_hh_r, 64'd0};
      e_geo_r.n_x   <= {d_xh_r, 32'd0} + {32'd0, d_xl_r};
      e_geo_r.n_y   <= {d_yh_r, 32'd0} + {32'd0, d_yl_r};
      e_geo_r.md    <= d_md_r;
      e_geo_r.neg_x <= d_negx_r;
      e_geo_r.neg_y <= d_negy_r;
      e_geo_r.zero  <= d_zero_r;
      e_geo_r.p1_x  <= d_p1x_r;
      e_geo_r.p1_y  <= d_p1y_r;
    end
  end

  assign out_v   = v_r[4];
  assign out_geo = e_geo_r;

endmodule

@@ rtl/core/lix2d_test.sv @@
`timescale 1ns / 1ps

module lix2d_test (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [30:0]        min_sine,
  input  logic               in_v,
  input  lix2d_pkg::geo_t    in_geo,
  output logic               out_v,
  output lix2d_pkg::div_in_t out_div
);
  import lix2d_pkg::*;

  logic [2:0]  v_r;
  logic [61:0] ms2_r;

  logic [63:0] pl_r [4];
  logic [63:0] ph_r [4];
  geo_t        a_geo_r;
  logic        a_bigx_r, a_bigy_r;

  logic [159:0] rl_nxt, rh_nxt;
  logic [159:0] b_rl_r, b_rh_r;
  geo_t         b_geo_r;
  logic         b_bigx_r, b_bigy_r;

  logic [191:0] lhs_nxt, rhs_nxt;
  div_in_t      c_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    ms2_r <= min_sine * min_sine;
  end

  always_comb begin
    rl_nxt = '0;
    rh_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      rl_nxt = rl_nxt + (160'(pl_r[k]) << (32 * k));
      rh_nxt = rh_nxt + (160'(ph_r[k]) << (32 * k));
    end
  end

  assign lhs_nxt = {2'd0, b_geo_r.sq, 62'd0};
  assign rhs_nxt = {32'd0, b_rl_r} + {b_rh_r, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pl_r[k] <= ms2_r[31:0] * in_geo.l12[32*k +: 32];
        ph_r[k] <= 64'(ms2_r[61:32] * in_geo.l12[32*k +: 32]);
      end
      a_geo_r  <= in_geo;
      a_bigx_r <= {8'd0, in_geo.n_x[95:QBITS]} >= in_geo.md;
      a_bigy_r <= {8'd0, in_geo.n_y[95:QBITS]} >= in_geo.md;

      b_rl_r   <= rl_nxt;
      b_rh_r   <= rh_nxt;
      b_geo_r  <= a_geo_r;
      b_bigx_r <= a_bigx_r;
      b_bigy_r <= a_bigy_r;

      c_div_r.n_x   <= b_geo_r.n_x;
      c_div_r.n_y   <= b_geo_r.n_y;
      c_div_r.md    <= b_geo_r.md;
      c_div_r.neg_x <= b_geo_r.neg_x;
      c_div_r.neg_y <= b_geo_r.neg_y;
      c_div_r.par   <= b_geo_r.zero || (lhs_nxt < rhs_nxt);
      c_div_r.big_x <= b_bigx_r;
      c_div_r.big_y <= b_bigy_r;
      c_div_r.p1_x  <= b_geo_r.p1_x;
      c_div_r.p1_y  <= b_geo_r.p1_y;
    end
  end

  assign out_v   = v_r[2];
  assign out_div = c_div_r;

endmodule

@@ rtl/core/lix2d_div.sv @@
`timescale 1ns / 1ps

module lix2d_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  lix2d_pkg::div_in_t in_div,
  output logic               out_v,
  output lix2d_pkg::div_st_t out_st
);
  import lix2d_pkg::*;

  // One quotient bit per stage for both coordinates; the upper dividend bits
  // seed the remainder, the lower ones are shifted out as quotient bits enter.
  function automatic div_st_t div_step(div_st_t s);
    div_st_t     o;
    logic [64:0] tx;
    logic [64:0] ty;
    o  = s;
    tx = {s.rem_x, s.acc_x[QBITS-1]};
    ty = {s.rem_y, s.acc_y[QBITS-1]};
    if (tx >= {1'b0, s.md}) begin
      o.rem_x = 64'(tx - {1'b0, s.md});
      o.acc_x = {s.acc_x[QBITS-2:0], 1'b1};
    end else begin
      o.rem_x = tx[63:0];
      o.acc_x = {s.acc_x[QBITS-2:0], 1'b0};
    end
    if (ty >= {1'b0, s.md}) begin
      o.rem_y = 64'(ty - {1'b0, s.md});
      o.acc_y = {s.acc_y[QBITS-2:0], 1'b1};
    end else begin
      o.rem_y = ty[63:0];
      o.acc_y = {s.acc_y[QBITS-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [QBITS-1:0] v_r;
  div_st_t          st_r  [QBITS];
  div_st_t          st_in [QBITS];

  always_comb begin
    st_in[0].rem_x = {8'd0, in_div.n_x[95:QBITS]};
    st_in[0].rem_y = {8'd0, in_div.n_y[95:QBITS]};
    st_in[0].md    = in_div.md;
    st_in[0].acc_x = in_div.n_x[QBITS-1:0];
    st_in[0].acc_y = in_div.n_y[QBITS-1:0];
    st_in[0].neg_x = in_div.neg_x;
    st_in[0].neg_y = in_div.neg_y;
    st_in[0].par   = in_div.par;
    st_in[0].big_x = in_div.big_x;
    st_in[0].big_y = in_div.big_y;
    st_in[0].p1_x  = in_div.p1_x;
    st_in[0].p1_y  = in_div.p1_y;
  end

  for (genvar g = 1; g < QBITS; g++) begin : g_link
    assign st_in[g] = st_r[g-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QBITS-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QBITS; k++) begin
        st_r[k] <= div_step(st_in[k]);
      end
    end
  end

  assign out_v  = v_r[QBITS-1];
  assign out_st = st_r[QBITS-1];

endmodule

@@ rtl/core/lix2d_out.sv @@
`timescale 1ns / 1ps

module lix2d_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  lix2d_pkg::div_st_t in_st,
  output logic               en,
  output logic               out_valid,
  input  logic               out_stall,
  output lix2d_pkg::res_t    out_res
);
  import lix2d_pkg::*;

  logic [1:0] v_r;

  logic [40:0] qx_nxt, qy_nxt;
  logic [QBITS-1:0] a_qx_r, a_qy_r;
  logic a_bigx_r, a_bigy_r, a_negx_r, a_negy_r, a_par_r;
  logic signed [31:0] a_p1x_r, a_p1y_r;

  logic [41:0] vx_nxt, vy_nxt;
  logic        ovx_nxt, ovy_nxt, satx_nxt, saty_nxt;
  logic [31:0] cx_nxt, cy_nxt;
  res_t        res_nxt;
  res_t        b_res_r;

  logic out_valid_r, skid_v_r;
  res_t out_res_r, skid_r;
  logic take, incoming;

  assign qx_nxt = {1'b0, in_st.acc_x}
                + 41'({in_st.rem_x, 1'b0} >= {1'b0, in_st.md});
  assign qy_nxt = {1'b0, in_st.acc_y}
                + 41'({in_st.rem_y, 1'b0} >= {1'b0, in_st.md});

  assign vx_nxt = a_negx_r ? {{10{a_p1x_r[31]}}, a_p1x_r} - {2'd0, a_qx_r}
                           : {{10{a_p1x_r[31]}}, a_p1x_r} + {2'd0, a_qx_r};
  assign vy_nxt = a_negy_r ? {{10{a_p1y_r[31]}}, a_p1y_r} - {2'd0, a_qy_r}
                           : {{10{a_p1y_r[31]}}, a_p1y_r} + {2'd0, a_qy_r};
  assign ovx_nxt = (vx_nxt[41:31] != '0) && (vx_nxt[41:31] != '1);
  assign ovy_nxt = (vy_nxt[41:31] != '0) && (vy_nxt[41:31] != '1);

  always_comb begin
    if (a_bigx_r) begin
      cx_nxt = a_negx_r ? COORD_MIN : COORD_MAX;
    end else if (ovx_nxt) begin
      cx_nxt = vx_nxt[41] ? COORD_MIN : COORD_MAX;
    end else begin
      cx_nxt = vx_nxt[31:0];
    end
    if (a_bigy_r) begin
      cy_nxt = a_negy_r ? COORD_MIN : COORD_MAX;
    end else if (ovy_nxt) begin
      cy_nxt = vy_nxt[41] ? COORD_MIN : COORD_MAX;
    end else begin
      cy_nxt = vy_nxt[31:0];
    end
    satx_nxt = a_bigx_r || ovx_nxt;
    saty_nxt = a_bigy_r || ovy_nxt;
    if (a_par_r) begin
      res_nxt.cross_x = '0;
      res_nxt.cross_y = '0;
      res_nxt.status  = STATUS_PARALLEL;
    end else begin
      res_nxt.cross_x = cx_nxt;
      res_nxt.cross_y = cy_nxt;
      res_nxt.status  = (satx_nxt || saty_nxt) ? STATUS_SAT : STATUS_OK;
    end
  end

  assign en       = !skid_v_r;
  assign take     = out_valid_r && !out_stall;
  assign incoming = en && v_r[1];

  always_ff @(posedge clk) begin
    if (en) begin
      a_qx_r   <= qx_nxt[QBITS-1:0];
      a_qy_r   <= qy_nxt[QBITS-1:0];
      a_bigx_r <= in_st.big_x || qx_nxt[40];
      a_bigy_r <= in_st.big_y || qy_nxt[40];
      a_negx_r <= in_st.neg_x;
      a_negy_r <= in_st.neg_y;
      a_par_r  <= in_st.par;
      a_p1x_r  <= in_st.p1_x;
      a_p1y_r  <= in_st.p1_y;
      b_res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[0], in_v};
      end
      if (skid_v_r) begin
        if (!out_valid_r || take) begin
          out_res_r   <= skid_r;
          out_valid_r <= 1'b1;
          skid_v_r    <= 1'b0;
        end
      end else if (incoming) begin
        if (!out_valid_r || take) begin
          out_res_r   <= b_res_r;
          out_valid_r <= 1'b1;
        end else begin
          skid_r   <= b_res_r;
          skid_v_r <= 1'b1;
        end
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ rtl/core/lix2d_checker.sv @@
`timescale 1ns / 1ps

`include "line_intersection_2d_defines.svh"

module lix2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_cross_x,
  input logic [31:0] out_cross_y,
  input logic [1:0]  out_status
);
  import lix2d_pkg::*;

  `LIX2D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LIX2D_ASSERT_NOW(a_par_zero, out_valid && (out_status == STATUS_PARALLEL), (out_cross_x == '0) && (out_cross_y == '0))
  `LIX2D_ASSERT_NOW(a_idle_open, !out_valid, !in_stall)
  `LIX2D_ASSERT_NEXT(a_drain_open, out_valid && !out_stall, !in_stall)

endmodule

bind line_intersection_2d lix2d_checker u_chk (.*);

@@ tb/line_intersection_2d_tb.sv @@
`timescale 1ns / 1ps

module line_intersection_2d_tb;
  import lix2d_pkg::*;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_beat_t beat;
    bit       known;
    res_t     res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_beat;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_cross_x;
  logic [31:0] out_cross_y;
  logic [1:0]  out_status;
  logic        cfg_wr_en;
  logic [30:0] cfg_wr_data;

  logic [30:0] min_sine;
  res_t        crossing_q[$];
  int          mismatches;
  int          cycles;
  bit          quiet;

  line_intersection_2d u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_p1_x    (in_beat.p1_x),
    .in_p1_y    (in_beat.p1_y),
    .in_dir1_x  (in_beat.dir1_x),
    .in_dir1_y  (in_beat.dir1_y),
    .in_p2_x    (in_beat.p2_x),
    .in_p2_y    (in_beat.p2_y),
    .in_dir2_x  (in_beat.dir2_x),
    .in_dir2_y  (in_beat.dir2_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_cross_x(out_cross_x),
    .out_cross_y(out_cross_y),
    .out_status (out_status),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] project_axis(input logic signed [127:0] p,
      input logic signed [127:0] r, input logic [63:0] mc, input bit negc,
      input logic [63:0] md, input bit negd, inout bit sat);
    logic [255:0]        num;
    logic [255:0]        quo;
    logic [255:0]        rem;
    logic [63:0]         mr;
    logic signed [127:0] qs;
    logic signed [127:0] v;
    bit                  neg;
    mr = (r < 0) ? 64'(-r) : 64'(r);
    num = {192'b0, mr} * {192'b0, mc};
    quo = num / {192'b0, md};
    rem = num % {192'b0, md};
    if (rem >= {192'b0, md} - rem) quo = quo + 1;
    neg = !((r < 0) ^ negc ^ negd);
    if (quo >= (256'd1 << QBITS)) begin
      sat = 1'b1;
      return neg ? COORD_MIN : COORD_MAX;
    end
    qs = $signed({87'b0, quo[40:0]});
    v = neg ? p - qs : p + qs;
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic res_t predict_crossing(input in_beat_t b, input logic [30:0] ms);
    logic signed [127:0] p1x, p1y, r1x, r1y, p2x, p2y, r2x, r2y;
    logic signed [127:0] l1, l2, d, c;
    logic [63:0]         md, mc;
    logic [255:0]        lhs, rhs;
    bit                  sat;
    res_t                res;
    p1x = $signed(b.p1_x);   p1y = $signed(b.p1_y);
    r1x = $signed(b.dir1_x); r1y = $signed(b.dir1_y);
    p2x = $signed(b.p2_x);   p2y = $signed(b.p2_y);
    r2x = $signed(b.dir2_x); r2y = $signed(b.dir2_y);
    sat = 1'b0;
    l1 = r1x * r1x + r1y * r1y;
    l2 = r2x * r2x + r2y * r2y;
    d = r1x * r2y - r1y * r2x;
    md = (d < 0) ? 64'(-d) : 64'(d);
    res = '{cross_x: 32'd0, cross_y: 32'd0, status: STATUS_PARALLEL};
    if (l1 != 0 && l2 != 0 && md != 0) begin
      lhs = ({192'b0, md} * {192'b0, md}) << 62;
      rhs = {225'b0, ms} * {225'b0, ms} * {128'b0, l1} * {128'b0, l2};
      if (lhs >= rhs) begin
        c = r2x * (p2y - p1y) - r2y * (p2x - p1x);
        mc = (c < 0) ? 64'(-c) : 64'(c);
        res.cross_x = project_axis(p1x, r1x, mc, c < 0, md, d < 0, sat);
        res.cross_y = project_axis(p1y, r1y, mc, c < 0, md, d < 0, sat);
        res.status = sat ? STATUS_SAT : STATUS_OK;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("line_intersection_2d_tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (crossing_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat %h %h %0d",
                                      out_cross_x, out_cross_y, out_status);
      end else begin
        want = crossing_q.pop_front();
        if (want.cross_x !== out_cross_x || want.cross_y !== out_cross_y ||
            want.status !== out_status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h %h %0d, got %h %h %0d", want.cross_x,
                     want.cross_y, want.status, out_cross_x, out_cross_y, out_status);
        end
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall = 1'b0;
        n = $urandom_range(1, 20);
      end else begin
        out_stall = 1'b1;
        n = $urandom_range(1, 14);
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  task automatic send_beat(input in_beat_t b, input bit known, input res_t res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_beat = b;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    crossing_q.push_back(known ? res : predict_crossing(b, min_sine));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (crossing_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_min_sine(input logic [30:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    min_sine = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] pick_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000);
      2: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      default: begin
        case ($urandom_range(0, 5))
          0: return SMIN;
          1: return SMAX;
          2: return 32'd0;
          3: return 32'd1;
          4: return 32'hFFFF_FFFF;
          default: return ONE;
        endcase
      end
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       kind;
    int       sel;
    sel = $urandom_range(0, 9);
    kind = (sel < 2) ? 0 : (sel < 8) ? 1 : 3;
    b.p1_x = pick_word(kind);   b.p1_y = pick_word(kind);
    b.p2_x = pick_word(kind);   b.p2_y = pick_word(kind);
    b.dir1_x = pick_word(kind); b.dir1_y = pick_word(kind);
    b.dir2_x = pick_word(kind); b.dir2_y = pick_word(kind);
    if (sel == 6 || sel == 7) begin
      b.dir2_x = b.dir1_x + pick_word(2) * $urandom_range(0, 1);
      b.dir2_y = b.dir1_y + pick_word(2) * $urandom_range(0, 1);
    end
    if (sel == 5) begin
      if ($urandom_range(0, 1)) {b.dir1_x, b.dir1_y} = '0;
      else {b.dir2_x, b.dir2_y} = '0;
    end
    return b;
  endfunction

  row_t rows[$];

  initial begin
    res_t par;
    res_t none;
    par = '{cross_x: 32'd0, cross_y: 32'd0, status: STATUS_PARALLEL};
    none = '{cross_x: 32'd0, cross_y: 32'd0, status: STATUS_OK};
    rows.push_back('{beat: '0, known: 1, res: par});
    rows.push_back('{beat: '{ONE, ONE, 0, 0, 0, 0, ONE, 0}, known: 1, res: par});
    rows.push_back('{beat: '{0, 0, ONE, 0, ONE, ONE, 2 * ONE, 0}, known: 1, res: par});
    rows.push_back('{beat: '{0, 0, ONE, 0, 3 * ONE, 5 * ONE, 0, ONE}, known: 1,
                     res: '{cross_x: 3 * ONE, cross_y: 0, status: STATUS_OK}});
    rows.push_back('{beat: '{0, 0, ONE, 0, 0, ONE, SMAX, 1}, known: 1, res: par});
    rows.push_back('{beat: '{0, 0, ONE, 0, SMAX, ONE, 0, ONE}, known: 1,
                     res: '{cross_x: SMAX, cross_y: 0, status: STATUS_OK}});
    rows.push_back('{beat: '{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN}, known: 1,
                     res: par});
    rows.push_back('{beat: '{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX}, known: 1,
                     res: par});
    rows.push_back('{beat: '{SMAX, SMIN, SMIN, SMAX, SMIN, SMAX, SMAX, SMIN}, known: 0,
                     res: none});
    rows.push_back('{beat: '{SMIN, SMAX, SMAX, 0, SMAX, SMIN, 0, SMIN}, known: 0,
                     res: none});
    rows.push_back('{beat: '{SMAX, 0, ONE, 0, 0, ONE, ONE, 1}, known: 0, res: none});
    rows.push_back('{beat: '{SMIN, 0, ONE, 0, 0, SMAX, 1, ONE}, known: 0, res: none});
    rows.push_back('{beat: '{0, 0, 1, 0, 0, 1, 1, 2}, known: 0, res: none});
    rows.push_back('{beat: '{0, 0, 1, 0, 0, 32'hFFFF_FFFF, 1, 2}, known: 0, res: none});
    rows.push_back('{beat: '{0, 0, ONE, ONE, 0, ONE, ONE, ONE + 1}, known: 0, res: none});
    rows.push_back('{beat: '{0, 0, 1, 1, 0, 1, 32'hFFFF_FFFF, 1}, known: 0, res: none});

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    min_sine = MIN_SINE_RESET;
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_beat(rows[i].beat, rows[i].known, rows[i].res);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_min_sine(31'd0);
        1: write_min_sine(31'h7FFF_FFFF);
        2: write_min_sine(31'($urandom_range(0, 32'h0100_0000)));
        default: write_min_sine(MIN_SINE_RESET);
      endcase
      foreach (rows[i]) if (!rows[i].known) send_beat(rows[i].beat, 0, none);
      for (int k = 0; k < 150; k++) begin
        if (phase == 1 && k == 75) drain();
        if (phase == 3 && k == 80) quiet = 1'b1;
        send_beat(random_beat(), 0, none);
      end
    end

    drain();
    if (mismatches == 0 && crossing_q.size() == 0) begin
      $display("line_intersection_2d_tb: PASS");
    end else begin
      $display("line_intersection_2d_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lix2d_pkg.sv
rtl/core/lix2d_front.sv
rtl/core/lix2d_test.sv
rtl/core/lix2d_div.sv
rtl/core/lix2d_out.sv
rtl/core/line_intersection_2d.sv
rtl/core/lix2d_checker.sv
tb/line_intersection_2d_tb.sv
